@@ src/ild_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ild_pkg;

  // Saturation point of the byte count.
  localparam int unsigned LENGTH_LIMIT = 63;
  localparam int unsigned CNT_W        = $clog2(LENGTH_LIMIT + 1);
  localparam int unsigned LEN_W        = 6;
  localparam int unsigned IN_W         = 8;
  localparam int unsigned OUT_W        = 16;

  localparam logic [7:0] PFX_OPSIZE  = 8'h66;
  localparam logic [7:0] ESC_0F      = 8'h0F;
  localparam logic [7:0] FPU_ESC     = 8'hD8;
  localparam logic [7:0] FPU_ESC_MSK = 8'hF8;
  localparam logic [7:0] NO_MODRM    = 8'hFF;

  typedef enum logic [2:0] {
    PH_PREFIX    = 3'd0,
    PH_AFTER_ESC = 3'd1,
    PH_OPCODE    = 3'd2,
    PH_MODRM     = 3'd3,
    PH_SIB       = 3'd4,
    PH_DISP      = 3'd5,
    PH_IMM       = 3'd6
  } ild_phase_t;

  typedef struct packed {
    ild_phase_t       phase;
    logic [CNT_W-1:0] cnt;
    logic             short_op;
    logic             two_byte;
    logic             fpu;
    logic [7:0]       opcode;
    logic [3:0]       disp_left;
    logic [2:0]       imm_left;
  } ild_state_t;

  typedef struct packed {
    logic             fpu_escape;
    logic             escape_0f;
    logic [7:0]       opcode_value;
    logic [LEN_W-1:0] instr_length;
  } ild_result_t;

  localparam ild_state_t STATE_RST = '{
    phase:     PH_PREFIX,
    cnt:       '0,
    short_op:  1'b0,
    two_byte:  1'b0,
    fpu:       1'b0,
    opcode:    8'h00,
    disp_left: 4'd0,
    imm_left:  3'd0
  };

  function automatic logic [CNT_W-1:0] cnt_inc(input logic [CNT_W-1:0] c);
    return (c < CNT_W'(LENGTH_LIMIT)) ? c + CNT_W'(1) : c;
  endfunction

  // Low six bits of the count, zero-extended when the count is narrower.
  function automatic logic [LEN_W-1:0] len_of(input logic [CNT_W-1:0] c);
    logic [CNT_W+LEN_W-1:0] wide;
    wide = {{LEN_W{1'b0}}, c};
    return wide[LEN_W-1:0];
  endfunction

  function automatic logic is_prefix(input logic [7:0] b);
    return b == 8'hF0 || b == 8'hF2 || b == 8'hF3 || b == 8'h66 ||
           b == 8'h67 || b == 8'h2E || b == 8'h3E || b == 8'h26 ||
           b == 8'h36 || b == 8'h64 || b == 8'h65;
  endfunction

  function automatic logic one_byte_has_modrm(input logic [7:0] op);
    return (op & 8'hC4) == 8'h00 ||
           ((op & 8'hF4) == 8'h60 &&
            ((op & 8'h0A) == 8'h02 || (op & 8'h09) == 8'h09)) ||
           (op & 8'hF0) == 8'h80 ||
           ((op & 8'hF8) == 8'hC0 && (op & 8'h0E) != 8'h02) ||
           (op & 8'hFC) == 8'hD0 ||
           (op & 8'hF6) == 8'hF6;
  endfunction

  function automatic logic two_byte_lacks_modrm(input logic [7:0] op);
    return ((op & 8'hF0) == 8'h00 && (op & 8'h0F) >= 8'h04 &&
            (op & 8'h0D) != 8'h0D) ||
           (op & 8'hF0) == 8'h30 ||
           op == 8'h77 ||
           (op & 8'hF0) == 8'h80 ||
           ((op & 8'hF0) == 8'hA0 && (op & 8'h07) <= 8'h02) ||
           (op & 8'hF8) == 8'hC8;
  endfunction

  function automatic logic [2:0] imm_size(input logic [7:0] op, input logic [7:0] m,
                                          input logic short_op, input logic two_byte,
                                          input logic fpu);
    logic [2:0] osz;
    logic       reg0;
    osz  = short_op ? 3'd2 : 3'd4;
    reg0 = (m & 8'h30) == 8'h00;
    if (fpu) return 3'd0;
    if (!two_byte) begin
      if ((op & 8'hC7) == 8'h04 || (op & 8'hFE) == 8'h6A ||
          (op & 8'hF0) == 8'h70 || op == 8'h80 || op == 8'h83 ||
          (op & 8'hFD) == 8'hA0 || op == 8'hA8 || op == 8'hB0 ||
          (op & 8'hFE) == 8'hC0 || op == 8'hC6 || op == 8'hCD ||
          (op & 8'hFE) == 8'hD4 || (op & 8'hF8) == 8'hE0 ||
          op == 8'hEB || (op == 8'hF6 && reg0))
        return 3'd1;
      if ((op & 8'hF7) == 8'hC2) return 3'd2;
      if ((op & 8'hFC) == 8'h80 || (op & 8'hC7) == 8'h05 ||
          (op & 8'hFE) == 8'hE8 || (op & 8'hFE) == 8'h68 ||
          (op & 8'hFC) == 8'hA0 || (op & 8'hEE) == 8'hA8 ||
          op == 8'hC7 || (op == 8'hF7 && reg0))
        return osz;
      return 3'd0;
    end
    if (op == 8'hBA || op == 8'h0F || (op & 8'hFC) == 8'h70 ||
        (op & 8'hF7) == 8'hA4 || op == 8'hC2 || op == 8'hC4 ||
        op == 8'hC5 || op == 8'hC6)
      return 3'd1;
    if ((op & 8'hF0) == 8'h80) return osz;
    return 3'd0;
  endfunction

  // Displacement bytes implied by a ModR/M byte (SIB base adds later).
  function automatic logic [3:0] disp_size(input logic [7:0] m);
    logic [3:0] d;
    d = 4'd0;
    if ((m & 8'hC5) == 8'h05) d = d + 4'd4;
    if (m[7:6] == 2'b01)      d = d + 4'd1;
    if (m[7:6] == 2'b10)      d = d + 4'd4;
    return d;
  endfunction

endpackage

`default_nettype wire

@@ src/ild_step.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ild_step
  import ild_pkg::*;
(
  input  ild_state_t  st,
  input  logic [7:0]  code_byte,
  output ild_state_t  st_next,
  output logic        res_valid,
  output ild_result_t res
);

  always_comb begin
    logic       take;
    logic       settle;
    logic       advance;
    logic [7:0] m_sel;
    logic [7:0] op_sel;
    logic [3:0] p_disp;
    logic [2:0] p_imm;
    logic [3:0] d;
    logic [2:0] imm;

    take      = 1'b0;
    settle    = 1'b0;
    advance   = 1'b0;
    m_sel     = NO_MODRM;
    op_sel    = st.opcode;
    p_disp    = st.disp_left;
    p_imm     = st.imm_left;
    d         = 4'd0;
    imm       = 3'd0;
    st_next   = st;
    res_valid = 1'b0;
    res       = '0;

    unique case (st.phase)
      PH_PREFIX: begin
        if (is_prefix(code_byte)) begin
          if (code_byte == PFX_OPSIZE) st_next.short_op = 1'b1;
          st_next.cnt = cnt_inc(st.cnt);
        end else if ((code_byte & FPU_ESC_MSK) == FPU_ESC) begin
          st_next.fpu   = 1'b1;
          st_next.cnt   = cnt_inc(st.cnt);
          st_next.phase = PH_AFTER_ESC;
        end else if (code_byte == ESC_0F) begin
          st_next.two_byte = 1'b1;
          st_next.cnt      = cnt_inc(st.cnt);
          st_next.phase    = PH_OPCODE;
        end else begin
          take = 1'b1;
        end
      end
      PH_AFTER_ESC: begin
        if (code_byte == ESC_0F) begin
          st_next.two_byte = 1'b1;
          st_next.cnt      = cnt_inc(st.cnt);
          st_next.phase    = PH_OPCODE;
        end else begin
          take = 1'b1;
        end
      end
      PH_OPCODE: take = 1'b1;
      PH_MODRM: begin
        st_next.cnt = cnt_inc(st.cnt);
        m_sel       = code_byte;
        settle      = 1'b1;
      end
      PH_SIB: begin
        st_next.cnt = cnt_inc(st.cnt);
        if (code_byte[2:0] == 3'd5) p_disp = st.disp_left + 4'd4;
        advance = 1'b1;
      end
      PH_DISP: begin
        st_next.cnt = cnt_inc(st.cnt);
        if (st.disp_left != 4'd0) p_disp = st.disp_left - 4'd1;
        advance = 1'b1;
      end
      PH_IMM: begin
        st_next.cnt = cnt_inc(st.cnt);
        if (st.imm_left != 3'd0) p_imm = st.imm_left - 3'd1;
        advance = 1'b1;
      end
      default: st_next = STATE_RST;
    endcase

    // Opcode byte: under an FPU escape it doubles as ModR/M unless mod is 3.
    if (take) begin
      st_next.opcode = code_byte;
      st_next.cnt    = cnt_inc(st.cnt);
      op_sel         = code_byte;
      if (st.fpu) begin
        if (code_byte[7:6] != 2'b11) m_sel = code_byte;
        settle = 1'b1;
      end else if (st.two_byte ? !two_byte_lacks_modrm(code_byte)
                               : one_byte_has_modrm(code_byte)) begin
        st_next.phase = PH_MODRM;
      end else begin
        settle = 1'b1;
      end
    end

    if (settle) begin
      d   = disp_size(m_sel);
      imm = imm_size(op_sel, m_sel, st.short_op, st.two_byte, st.fpu);
      st_next.disp_left = d;
      st_next.imm_left  = imm;
      if (m_sel[2:0] == 3'd4 && m_sel[7:6] != 2'b11) begin
        st_next.phase = PH_SIB;
      end else begin
        p_disp  = d;
        p_imm   = imm;
        advance = 1'b1;
      end
    end

    if (advance) begin
      st_next.disp_left = p_disp;
      st_next.imm_left  = p_imm;
      if (p_disp != 4'd0) begin
        st_next.phase = PH_DISP;
      end else if (p_imm != 3'd0) begin
        st_next.phase = PH_IMM;
      end else begin
        res_valid        = 1'b1;
        res.instr_length = len_of(st_next.cnt);
        res.opcode_value = st_next.opcode;
        res.escape_0f    = st.two_byte;
        res.fpu_escape   = st.fpu;
        st_next          = STATE_RST;
      end
    end
  end

endmodule

`default_nettype wire

@@ src/ild_out_reg.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ild_out_reg
  import ild_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  ild_result_t res,
  input  logic        take,
  output logic        valid,
  output ild_result_t res_q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (take) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_q <= res;
    end
  end

endmodule

`default_nettype wire

@@ src/x86_instruction_length_decoder_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel | Dir | Width | Contents
// s_axis  | in  | 8     | code_byte, one byte of the code stream per transfer
// m_axis  | out | 16    | instr_length, opcode_value, escape_0f, fpu_escape
//
// One code byte per cycle while s_axis_tready is high; each byte is
// folded into the decode state in the same cycle it is taken, so the
// decode state register is the only loop; results are registered.
// rst returns the decoder to the prefix phase and empties the output.
// While a result waits on m_axis, s_axis_tready drops; it rises again in
// the cycle the result is taken, so no cycle is lost when m_axis_tready
// stays high.

module x86_instruction_length_decoder_core
  import ild_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [IN_W-1:0]  s_axis_tdata,   // [7:0] code_byte
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata    // [5:0] instr_length, [13:6] opcode_value,
                                           // [14] escape_0f, [15] fpu_escape
);

  ild_state_t  st;
  ild_state_t  st_next;
  ild_result_t step_res;
  ild_result_t res_q;
  logic        step_valid;
  logic        accept;

  // Take a byte whenever the result slot is empty or being drained.
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  ild_step u_step (
    .st        (st),
    .code_byte (s_axis_tdata),
    .st_next   (st_next),
    .res_valid (step_valid),
    .res       (step_res)
  );

  // Advance the decode state only on an accepted transfer; hold otherwise.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= STATE_RST;
    end else if (accept) begin
      st <= st_next;
    end
  end

  ild_out_reg u_out (
    .clk   (clk),
    .rst   (rst),
    .load  (accept && step_valid),
    .res   (step_res),
    .take  (m_axis_tready),
    .valid (m_axis_tvalid),
    .res_q (res_q)
  );

  assign m_axis_tdata = res_q;

endmodule

`default_nettype wire

@@ src/ild_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ild_checker
  import ild_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic [IN_W-1:0]  s_axis_tdata,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_rst_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result present after reset");

  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[LEN_W-1:0] != '0)
    else $error("zero instruction length");

  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  a_result_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tdata == s_axis_tdata))
    else $error("result without an input transfer");

endmodule

bind x86_instruction_length_decoder_core ild_checker u_ild_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

@@ dv/tb_x86_instruction_length_decoder_core.sv @@
`timescale 1ns / 1ps

module tb_x86_instruction_length_decoder_core
  import ild_pkg::*;
;

  localparam int unsigned RANDOM_BYTES = 890;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned MAX_PRINTED  = 100;
  // Receiver hold-off: start point (accepted bytes) and length (cycles).
  localparam int unsigned HOLD_AT      = 850;
  localparam int unsigned HOLD_LEN     = 300;

  localparam logic [7:0] LEGACY_PREFIXES [11] = '{
    8'hF0, 8'hF2, 8'hF3, 8'h66, 8'h67, 8'h2E, 8'h3E, 8'h26, 8'h36, 8'h64, 8'h65
  };

  // Decode context of the length decoder, kept by the generator and by the checker.
  typedef struct {
    ild_phase_t  stage;
    int unsigned count;
    bit          opsize16;
    bit          esc0f;
    bit          esc_fpu;
    logic [7:0]  op;
    logic [7:0]  modrm;
    int unsigned disp_n;
    int unsigned imm_n;
  } decode_ctx_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata = '0;   // [7:0] code_byte
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;        // [5:0] instr_length, [13:6] opcode_value,
                                         // [14] escape_0f, [15] fpu_escape

  logic [7:0]  pending_bytes[$];
  ild_result_t expected_results[$];
  decode_ctx_t gen_ctx;
  decode_ctx_t chk_ctx;
  int unsigned bytes_taken = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;

  x86_instruction_length_decoder_core uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #4 clk = ~clk;

  function automatic decode_ctx_t fresh_ctx();
    decode_ctx_t c;
    c.stage    = PH_PREFIX;
    c.count    = 0;
    c.opsize16 = 1'b0;
    c.esc0f    = 1'b0;
    c.esc_fpu  = 1'b0;
    c.op       = 8'h00;
    c.modrm    = NO_MODRM;
    c.disp_n   = 0;
    c.imm_n    = 0;
    return c;
  endfunction

  function automatic bit is_legacy_prefix(input logic [7:0] b);
    foreach (LEGACY_PREFIXES[i])
      if (b == LEGACY_PREFIXES[i]) return 1'b1;
    return 1'b0;
  endfunction

  function automatic bit opcode_takes_modrm(input logic [7:0] op);
    return (op & 8'hC4) == 8'h00 ||
           ((op & 8'hF4) == 8'h60 && ((op & 8'h0A) == 8'h02 || (op & 8'h09) == 8'h09)) ||
           op[7:4] == 4'h8 ||
           (op[7:3] == 5'b11000 && (op & 8'h0E) != 8'h02) ||
           op[7:2] == 6'b110100 ||
           (op & 8'hF6) == 8'hF6;
  endfunction

  function automatic bit ext_opcode_skips_modrm(input logic [7:0] op);
    return (op[7:4] == 4'h0 && op[3:0] >= 4'h4 && (op & 8'h0D) != 8'h0D) ||
           op[7:4] == 4'h3 ||
           op == 8'h77 ||
           op[7:4] == 4'h8 ||
           (op[7:4] == 4'hA && op[2:0] <= 3'd2) ||
           op[7:3] == 5'b11001;
  endfunction

  // Immediate byte count; only bits 5:4 of ModR/M select the F6/F7 immediate.
  function automatic int unsigned immediate_bytes(input decode_ctx_t c, input logic [7:0] op,
                                                  input logic [7:0] m);
    int unsigned wide;
    bit          reg_zero;
    wide     = c.opsize16 ? 2 : 4;
    reg_zero = (m[5:4] == 2'b00);
    if (c.esc_fpu) return 0;
    if (!c.esc0f) begin
      if ((op & 8'hC7) == 8'h04 || (op & 8'hFE) == 8'h6A || op[7:4] == 4'h7 ||
          op == 8'h80 || op == 8'h83 || (op & 8'hFD) == 8'hA0 || op == 8'hA8 ||
          op == 8'hB0 || (op & 8'hFE) == 8'hC0 || op == 8'hC6 || op == 8'hCD ||
          (op & 8'hFE) == 8'hD4 || op[7:3] == 5'b11100 || op == 8'hEB ||
          (op == 8'hF6 && reg_zero))
        return 1;
      if ((op & 8'hF7) == 8'hC2) return 2;
      if (op[7:2] == 6'b100000 || (op & 8'hC7) == 8'h05 || (op & 8'hFE) == 8'hE8 ||
          (op & 8'hFE) == 8'h68 || op[7:2] == 6'b101000 || (op & 8'hEE) == 8'hA8 ||
          op == 8'hC7 || (op == 8'hF7 && reg_zero))
        return wide;
      return 0;
    end
    if (op == 8'hBA || op == ESC_0F || op[7:2] == 6'b011100 || (op & 8'hF7) == 8'hA4 ||
        op == 8'hC2 || op == 8'hC4 || op == 8'hC5 || op == 8'hC6)
      return 1;
    if (op[7:4] == 4'h8) return wide;
    return 0;
  endfunction

  // Fold one code byte into the context; return 1 when an instruction ends.
  function automatic bit decode_byte(inout decode_ctx_t c, input logic [7:0] b,
                                     output ild_result_t r);
    bit opcode_now;
    bit settle;
    bit advance;
    bit done;
    opcode_now = 1'b0;
    settle     = 1'b0;
    advance    = 1'b0;
    done       = 1'b0;
    r          = '0;
    case (c.stage)
      PH_PREFIX, PH_AFTER_ESC: begin
        if (c.stage == PH_PREFIX && is_legacy_prefix(b)) begin
          if (b == PFX_OPSIZE) c.opsize16 = 1'b1;
          if (c.count < LENGTH_LIMIT) c.count++;
        end else if (c.stage == PH_PREFIX && (b & FPU_ESC_MSK) == FPU_ESC) begin
          c.esc_fpu = 1'b1;
          if (c.count < LENGTH_LIMIT) c.count++;
          c.stage = PH_AFTER_ESC;
        end else if (b == ESC_0F) begin
          c.esc0f = 1'b1;
          if (c.count < LENGTH_LIMIT) c.count++;
          c.stage = PH_OPCODE;
        end else begin
          opcode_now = 1'b1;
        end
      end
      PH_OPCODE: opcode_now = 1'b1;
      PH_MODRM: begin
        c.modrm = b;
        if (c.count < LENGTH_LIMIT) c.count++;
        settle = 1'b1;
      end
      PH_SIB: begin
        if (c.count < LENGTH_LIMIT) c.count++;
        if (b[2:0] == 3'd5) c.disp_n += 4;
        advance = 1'b1;
      end
      PH_DISP: begin
        if (c.count < LENGTH_LIMIT) c.count++;
        if (c.disp_n > 0) c.disp_n--;
        advance = 1'b1;
      end
      PH_IMM: begin
        if (c.count < LENGTH_LIMIT) c.count++;
        if (c.imm_n > 0) c.imm_n--;
        advance = 1'b1;
      end
      default: c = fresh_ctx();
    endcase
    if (opcode_now) begin
      c.op = b;
      if (c.count < LENGTH_LIMIT) c.count++;
      c.modrm = NO_MODRM;
      if (c.esc_fpu) begin
        // the FPU opcode doubles as ModR/M unless it is a register form
        if (b[7:6] != 2'b11) c.modrm = b;
        settle = 1'b1;
      end else if (c.esc0f ? !ext_opcode_skips_modrm(b) : opcode_takes_modrm(b)) begin
        c.stage = PH_MODRM;
      end else begin
        settle = 1'b1;
      end
    end
    if (settle) begin
      c.imm_n  = immediate_bytes(c, c.op, c.modrm);
      c.disp_n = 0;
      if ((c.modrm & 8'hC5) == 8'h05) c.disp_n += 4;
      if (c.modrm[7:6] == 2'b01) c.disp_n += 1;
      if (c.modrm[7:6] == 2'b10) c.disp_n += 4;
      if (c.modrm[2:0] == 3'd4 && c.modrm[7:6] != 2'b11) c.stage = PH_SIB;
      else advance = 1'b1;
    end
    if (advance) begin
      if (c.disp_n > 0) begin
        c.stage = PH_DISP;
      end else if (c.imm_n > 0) begin
        c.stage = PH_IMM;
      end else begin
        r.instr_length = LEN_W'(c.count);
        r.opcode_value = c.op;
        r.escape_0f    = c.esc0f;
        r.fpu_escape   = c.esc_fpu;
        c    = fresh_ctx();
        done = 1'b1;
      end
    end
    return done;
  endfunction

  // Queue one byte for the driver and track where the stream stands.
  function automatic bit feed_byte(input logic [7:0] b);
    ild_result_t unused;
    pending_bytes.push_back(b);
    return decode_byte(gen_ctx, b, unused);
  endfunction

  function automatic logic [7:0] pick_modrm();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 3) return {2'($urandom_range(0, 2)), 3'($urandom_range(0, 7)), 3'd4};
    if (sel < 5) return {2'b00, 3'($urandom_range(0, 7)), 3'd5};
    if (sel == 5) return {2'b00, 3'($urandom_range(0, 7)), 3'd7};
    return 8'($urandom_range(0, 255));
  endfunction

  // Mostly well-formed instructions with random content; some raw noise.
  task automatic queue_instruction();
    logic [7:0] b;
    bit         fin;
    if ($urandom_range(0, 99) < 8) begin
      repeat ($urandom_range(1, 6)) void'(feed_byte(8'($urandom_range(0, 255))));
      return;
    end
    if ($urandom_range(0, 99) == 0) begin
      repeat ($urandom_range(60, 70))
        void'(feed_byte(LEGACY_PREFIXES[$urandom_range(0, 10)]));
    end else if ($urandom_range(0, 99) < 30) begin
      repeat ($urandom_range(1, 3)) void'(feed_byte(LEGACY_PREFIXES[$urandom_range(0, 10)]));
    end
    if ($urandom_range(0, 99) < 15) void'(feed_byte(FPU_ESC | 8'($urandom_range(0, 7))));
    if ($urandom_range(0, 99) < 25) void'(feed_byte(ESC_0F));
    fin = 1'b0;
    while (!fin) begin
      case (gen_ctx.stage)
        PH_MODRM: b = pick_modrm();
        PH_SIB: b = ($urandom_range(0, 9) < 4) ? {5'($urandom_range(0, 31)), 3'd5}
                                               : 8'($urandom_range(0, 255));
        default: b = 8'($urandom_range(0, 255));
      endcase
      fin = feed_byte(b);
    end
  endtask

  task automatic report_mismatch(input string what, input int unsigned got_v,
                                 input int unsigned want_v);
    if (mismatches < MAX_PRINTED)
      $display("MISMATCH result %0d %s: got 0x%0h expected 0x%0h",
               results_seen, what, got_v, want_v);
    mismatches++;
  endtask

  // Idle rates per stage of the run: sender-light, receiver-light, then none.
  always_comb begin
    if (bytes_taken < 400) begin
      tx_idle_pct = 13;
      rx_idle_pct = 78;
    end else if (bytes_taken < 750) begin
      tx_idle_pct = 78;
      rx_idle_pct = 13;
    end else begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
  end

  // Sender: present the next byte once the previous transfer is done.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        s_axis_tdata  <= pending_bytes.pop_front();
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure plus one long hold-off once HOLD_AT bytes are taken.
  always @(posedge clk) begin : receiver
    int unsigned hold_left;
    bit          hold_done;
    if (rst) begin
      m_axis_tready <= 1'b0;
      hold_left = 0;
      hold_done = 1'b0;
    end else begin
      if (!hold_done && bytes_taken >= HOLD_AT) begin
        hold_left = HOLD_LEN;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // Monitor: predict on each accepted code byte, check each result transfer.
  always @(posedge clk) begin : monitor
    ild_result_t predicted;
    ild_result_t got;
    ild_result_t want;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        bytes_taken <= bytes_taken + 1;
        if (decode_byte(chk_ctx, s_axis_tdata, predicted))
          expected_results.push_back(predicted);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = ild_result_t'(m_axis_tdata);
        if (expected_results.size() == 0) begin
          report_mismatch("with nothing expected", m_axis_tdata, 0);
        end else begin
          want = expected_results.pop_front();
          if (got.instr_length != want.instr_length)
            report_mismatch("instr_length", got.instr_length, want.instr_length);
          if (got.opcode_value != want.opcode_value)
            report_mismatch("opcode_value", got.opcode_value, want.opcode_value);
          if (got.escape_0f != want.escape_0f)
            report_mismatch("escape_0f", got.escape_0f, want.escape_0f);
          if (got.fpu_escape != want.fpu_escape)
            report_mismatch("fpu_escape", got.fpu_escape, want.fpu_escape);
        end
        results_seen++;
      end
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin : stimulus
    logic [7:0]  directed[$];
    int unsigned target;
    gen_ctx = fresh_ctx();
    chk_ctx = fresh_ctx();
    // Directed: no ModR/M, ModR/M forms, SIB with base 5, mod 0 r/m 5 and 7,
    // operand-size prefix, F6/F7 reg selection, 0F forms, FPU escapes, all-ones bytes.
    directed = '{
      8'h90,
      8'h00, 8'h00,
      8'h66, 8'h81, 8'hC0, 8'h34, 8'h12,
      8'h81, 8'h05, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66, 8'h77, 8'h88,
      8'h8B, 8'h44, 8'h25, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05,
      8'h8B, 8'h07, 8'hAA, 8'hBB, 8'hCC, 8'hDD,
      8'hF6, 8'hC0, 8'h7F,
      8'hF6, 8'hD0,
      8'hF7, 8'h00, 8'h01, 8'h02, 8'h03, 8'h04,
      8'h66, 8'hF7, 8'h00, 8'h01, 8'h02,
      8'hC2, 8'h10, 8'h00,
      8'h0F, 8'h80, 8'h10, 8'h20, 8'h30, 8'h40,
      8'h0F, 8'h05,
      8'h0F, 8'hBA, 8'hE0, 8'h05,
      8'hD9, 8'hC0,
      8'hD8, 8'h05, 8'h01, 8'h02, 8'h03, 8'h04,
      8'hDD, 8'h0F, 8'h44, 8'h25, 8'h09, 8'h01, 8'h02, 8'h03, 8'h04,
      8'hFF, 8'hFF,
      8'hE8, 8'h00, 8'h00, 8'h00, 8'h00
    };
    foreach (directed[i]) void'(feed_byte(directed[i]));
    // Endless prefixes: the count pins at the limit until the opcode arrives.
    repeat (70) void'(feed_byte(8'hF3));
    void'(feed_byte(8'h90));
    target = pending_bytes.size() + RANDOM_BYTES;
    while (pending_bytes.size() < target) queue_instruction();

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Drain: all bytes taken, all results back, then a few quiet cycles.
    while (pending_bytes.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
